// ===== hdl/mcam_pkg.sv =====
package mcam_pkg;

    // Block sizes
    localparam int CHANNELS       = 5;
    localparam int SINE_ADDR_BITS = 10;
    localparam int AUDIO_BITS     = 16;
    localparam int INPUT_FIELDS   = 5;

    // Channels loaded from ports; the rest carry silence
    localparam int IN_LOAD = (CHANNELS < INPUT_FIELDS) ? CHANNELS : INPUT_FIELDS;
    localparam int CNT_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Sine table
    localparam int QBITS       = SINE_ADDR_BITS - 2;
    localparam int QSIZE       = 1 << QBITS;
    localparam int TAB_ADDR_W  = QBITS + 1;
    localparam int SINE_W      = 16;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // Datapath widths
    localparam int SUM_W    = 20;
    localparam int SUM_MAX  = (1 << (SUM_W - 1)) - 1;
    localparam int SUM_MIN  = -(1 << (SUM_W - 1));
    localparam int MUL_A_W  = (AUDIO_BITS + 1 > SUM_W) ? AUDIO_BITS + 1 : SUM_W;
    localparam int PROD_W   = MUL_A_W + SINE_W;
    localparam int ACC_W    = MUL_A_W + SINE_W + 3;
    localparam int PHASE_W  = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING_STEP = 2'd2;

    localparam logic [PHASE_W-1:0] MIX_STEP_RST     = 32'd894784853;
    localparam logic [PHASE_W-1:0] FIRST_STEP_RST   = 32'd823202065;
    localparam logic [PHASE_W-1:0] SPACING_STEP_RST = 32'd35791394;
    localparam logic [PHASE_W-1:0] QUARTER_TURN     = 32'h4000_0000;

    typedef logic [14:0] t_sine_tab [0:QSIZE];

    // Quarter-wave table from an integer Taylor series, evaluated at elaboration
    function automatic t_sine_tab f_build_sine_tab();
        t_sine_tab          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic signed [63:0] v;
        for (int k = 0; k <= QSIZE; k++) begin
            x    = (64'(HALF_PI_Q30) * 64'(k)) >> QBITS;
            x2   = (x * x) >> 30;
            term = x;
            s    = $signed(x);
            // terms x^3/3! .. x^13/13!, alternating sign
            term = ((term * x2) >> 30) / 64'd6;
            s    = s - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            s    = s + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            s    = s - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            s    = s + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            s    = s - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            s    = s + $signed(term);
            if (s < 0) begin
                s = 64'sd0;
            end
            v = (s * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
            if (v > 64'sd32767) begin
                v = 64'sd32767;
            end
            tab[k] = v[14:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine_tab();

    // Q1.15 sine of a full-turn phase
    function automatic logic signed [SINE_W-1:0] f_sine(input logic [PHASE_W-1:0] phase);
        logic [SINE_ADDR_BITS-1:0] idx;
        logic [TAB_ADDR_W-1:0]     addr;
        logic [SINE_W-1:0]         mag;
        idx = phase[PHASE_W-1 -: SINE_ADDR_BITS];
        if (idx[SINE_ADDR_BITS-2]) begin
            addr = TAB_ADDR_W'(QSIZE) - {1'b0, idx[QBITS-1:0]};
        end else begin
            addr = {1'b0, idx[QBITS-1:0]};
        end
        mag = {1'b0, SINE_TAB[addr]};
        return idx[SINE_ADDR_BITS-1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_chan;
        logic mul_i;
        logic mul_q;
        logic acc_add;
        logic sum_en;
        logic quant_i;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/mcam_ctrl.sv =====
module mcam_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mcam_pkg::t_dp_stat i_stat,
    output mcam_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_ACC,
        S_SUM,
        S_MULI,
        S_MULQ,
        S_FIN
    } t_state;

    localparam logic [mcam_pkg::CNT_W-1:0] CHAN_LAST =
        mcam_pkg::CNT_W'(mcam_pkg::CHANNELS - 1);

    t_state                      r_state, n_state;
    logic [mcam_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHAN;
                    n_cnt   = '0;
                end
            end
            S_CHAN: begin
                if (r_cnt == CHAN_LAST) begin
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ACC:  n_state = S_SUM;
            S_SUM:  n_state = S_MULI;
            S_MULI: n_state = S_MULQ;
            S_MULQ: n_state = S_FIN;
            S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_chan = (r_state == S_CHAN);
        o_cmd.acc_add  = ((r_state == S_CHAN) && (r_cnt != '0)) || (r_state == S_ACC);
        o_cmd.sum_en   = (r_state == S_SUM);
        o_cmd.mul_i    = (r_state == S_MULI);
        o_cmd.mul_q    = (r_state == S_MULQ);
        o_cmd.quant_i  = (r_state == S_MULQ);
        o_cmd.finish   = (r_state == S_FIN) && i_stat.out_free;
    end

endmodule

// ===== hdl/mcam_datapath.sv =====
module mcam_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [mcam_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mcam_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [mcam_pkg::AUDIO_BITS-1:0]       i_audio [mcam_pkg::INPUT_FIELDS],
    input  mcam_pkg::t_dp_cmd                     i_cmd,
    output mcam_pkg::t_dp_stat                    o_stat,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_i_byte,
    output logic [7:0]                            o_q_byte,
    output logic                                  o_over_range
);

    localparam int AB      = mcam_pkg::AUDIO_BITS;
    localparam int ACC_W   = mcam_pkg::ACC_W;
    localparam int PROD_W  = mcam_pkg::PROD_W;
    localparam int MUL_A_W = mcam_pkg::MUL_A_W;
    localparam int SUM_W   = mcam_pkg::SUM_W;
    localparam int PH_W    = mcam_pkg::PHASE_W;
    localparam int NCH     = mcam_pkg::CHANNELS;
    localparam int ROUND_HALF = 1 << (AB - 2);
    // x / 5 == (x * RECIP5) >> 18 for all x below 2^16
    localparam logic [26:0] RECIP5 = 27'd52429;
    // full scale 10.0 in Q.30
    localparam logic [PROD_W-1:0] OVER_LIMIT = PROD_W'(64'd10 << 30);

    // |p| <= 2^19 * 2^15, so the quotient digits sit in mag[34:24]
    function automatic logic [7:0] f_quant(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [10:0]       m;
        logic [26:0]       qm;
        logic [8:0]        q;
        logic [10:0]       rm;
        logic [2:0]        r5;
        logic [23:0]       low;
        logic              up;
        logic [8:0]        qr;
        logic signed [9:0] sv;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        m   = mag[34:24];
        low = mag[23:0];
        qm  = 27'(m) * RECIP5;
        q   = qm[26:18];
        rm  = m - (11'(q) * 11'd5);
        r5  = rm[2:0];
        up  = (r5 > 3'd2)
           || ((r5 == 3'd2) && (low > 24'h80_0000))
           || ((r5 == 3'd2) && (low == 24'h80_0000) && q[0]);
        qr  = q + 9'(up);
        if (p[PROD_W-1]) begin
            sv = 10'sd128 - $signed({1'b0, qr});
        end else begin
            sv = 10'sd128 + $signed({1'b0, qr});
        end
        if (sv < 10'sd0) begin
            return 8'd0;
        end else if (sv > 10'sd255) begin
            return 8'd255;
        end
        return sv[7:0];
    endfunction

    function automatic logic f_over(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        return mag > OVER_LIMIT;
    endfunction

    logic [PH_W-1:0]          r_mix_step, r_first_step, r_space_step;
    logic [PH_W-1:0]          r_phase [NCH];
    logic [PH_W-1:0]          r_mix_phase;
    logic [PH_W-1:0]          r_step;
    logic [AB-1:0]            r_audio [NCH];
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [7:0]               r_qi;
    logic                     r_ovr_i;
    logic                     r_flag, n_flag;
    logic                     r_out_valid;
    logic [7:0]               r_i_byte, r_q_byte;
    logic                     r_over;

    logic signed [MUL_A_W-1:0]               s_mul_a;
    logic signed [mcam_pkg::SINE_W-1:0]      s_mul_b;
    logic [PH_W-1:0]                         s_mul_phase;
    logic signed [ACC_W-1:0]                 s_round, s_shift;

    // Shared multiplier: envelope or sum times a table sine
    always_comb begin
        s_mul_a     = '0;
        s_mul_phase = r_phase[0];
        if (i_cmd.mul_chan) begin
            s_mul_a = $signed(MUL_A_W'({~r_audio[0][AB-1], r_audio[0][AB-2:0]}));
        end else if (i_cmd.mul_i) begin
            s_mul_a     = MUL_A_W'(r_sum);
            s_mul_phase = r_mix_phase;
        end else if (i_cmd.mul_q) begin
            s_mul_a     = MUL_A_W'(r_sum);
            s_mul_phase = r_mix_phase + mcam_pkg::QUARTER_TURN;
        end
        s_mul_b = mcam_pkg::f_sine(s_mul_phase);
        n_prod  = PROD_W'(s_mul_a) * PROD_W'(s_mul_b);
    end

    // Round half up to Q4.15, then saturate
    always_comb begin
        s_round = r_acc + ACC_W'(ROUND_HALF);
        s_shift = s_round >>> (AB - 1);
        if (s_shift > ACC_W'(mcam_pkg::SUM_MAX)) begin
            n_sum = SUM_W'(mcam_pkg::SUM_MAX);
        end else if (s_shift < ACC_W'(mcam_pkg::SUM_MIN)) begin
            n_sum = SUM_W'(mcam_pkg::SUM_MIN);
        end else begin
            n_sum = s_shift[SUM_W-1:0];
        end
    end

    assign n_flag = r_flag | r_ovr_i | f_over(r_prod);

    // Config and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_step   <= mcam_pkg::MIX_STEP_RST;
            r_first_step <= mcam_pkg::FIRST_STEP_RST;
            r_space_step <= mcam_pkg::SPACING_STEP_RST;
            for (int c = 0; c < NCH; c++) begin
                r_phase[c] <= '0;
            end
            r_mix_phase  <= '0;
            r_flag       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_over       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mcam_pkg::CFG_MIX_STEP:     r_mix_step   <= i_cfg_data;
                    mcam_pkg::CFG_FIRST_STEP:   r_first_step <= i_cfg_data;
                    mcam_pkg::CFG_SPACING_STEP: r_space_step <= i_cfg_data;
                    default: ;
                endcase
            end
            // phases rotate through slot 0, each advanced as it passes
            if (i_cmd.mul_chan) begin
                for (int c = 0; c < NCH - 1; c++) begin
                    r_phase[c] <= r_phase[c+1];
                end
                r_phase[NCH-1] <= r_phase[0] + r_step;
            end
            if (i_cmd.finish) begin
                r_mix_phase <= r_mix_phase + r_mix_step;
                r_flag      <= n_flag;
                r_over      <= n_flag;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int c = 0; c < NCH; c++) begin
                if (c < mcam_pkg::IN_LOAD) begin
                    r_audio[c] <= i_audio[c];
                end else begin
                    r_audio[c] <= '0;
                end
            end
            r_step <= r_first_step;
            r_acc  <= '0;
        end else begin
            if (i_cmd.mul_chan) begin
                for (int c = 0; c < NCH - 1; c++) begin
                    r_audio[c] <= r_audio[c+1];
                end
                r_audio[NCH-1] <= r_audio[0];
                r_step         <= r_step + r_space_step;
            end
            if (i_cmd.acc_add) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (i_cmd.mul_chan || i_cmd.mul_i || i_cmd.mul_q) begin
            r_prod <= n_prod;
        end
        if (i_cmd.sum_en) begin
            r_sum <= n_sum;
        end
        if (i_cmd.quant_i) begin
            r_qi    <= f_quant(r_prod);
            r_ovr_i <= f_over(r_prod);
        end
        if (i_cmd.finish) begin
            r_i_byte <= r_qi;
            r_q_byte <= f_quant(r_prod);
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_i_byte        = r_i_byte;
    assign o_q_byte        = r_q_byte;
    assign o_over_range    = r_over;

endmodule

// ===== hdl/multi_carrier_am_iq_generator.sv =====
// Multi-carrier AM generator with quadrature mixer.
// Input channel (i_in_valid / o_in_ready): one word holds one Q1.15 audio sample for
// each channel. Each channel modulates its own carrier as (1 + a) * sin(phase), the
// terms are summed to Q4.15 and mixed by a local oscillator into I and Q.
// Output channel (o_out_valid / i_out_ready): one word per input word, I and Q as
// offset-binary bytes plus a sticky over-range flag.
// Config port: i_cfg_wr_en, i_cfg_index, i_cfg_data; write only while idle.
//   index 0 mixer step, 1 first carrier step, 2 carrier spacing; others ignored.
// Schedule: one shared multiplier does all products, one per cycle: CHANNELS channel
//   products, then I and Q. The result word is loaded into the output register after
//   the Q product; a new input word is accepted only after the last one has been
//   handed to the output register.
// Stall: the finished word waits in the output register. The next input word is
//   accepted and computed meanwhile; it holds in its final step until the output
//   register frees.
// Reset (i_rst_n low, synchronous): phases and over-range flag clear, config
//   registers return to their defaults, both channels go empty.
module multi_carrier_am_iq_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mcam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mcam_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mcam_pkg::AUDIO_BITS-1:0]     i_audio_ch0,
    input  logic [mcam_pkg::AUDIO_BITS-1:0]     i_audio_ch1,
    input  logic [mcam_pkg::AUDIO_BITS-1:0]     i_audio_ch2,
    input  logic [mcam_pkg::AUDIO_BITS-1:0]     i_audio_ch3,
    input  logic [mcam_pkg::AUDIO_BITS-1:0]     i_audio_ch4,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [7:0]                          o_i_byte,
    output logic [7:0]                          o_q_byte,
    output logic                                o_over_range
);

    mcam_pkg::t_dp_cmd  s_cmd;
    mcam_pkg::t_dp_stat s_stat;
    logic [mcam_pkg::AUDIO_BITS-1:0] s_audio [mcam_pkg::INPUT_FIELDS];

    // audio ports gathered in channel order
    assign s_audio[0] = i_audio_ch0;
    assign s_audio[1] = i_audio_ch1;
    assign s_audio[2] = i_audio_ch2;
    assign s_audio[3] = i_audio_ch3;
    assign s_audio[4] = i_audio_ch4;

    // sequencer: walks channels, sum, I, Q and output hand-off
    mcam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // phase accumulators, shared multiplier, quantizer and output register
    mcam_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_audio      (s_audio),
        .i_cmd        (s_cmd),
        .o_stat       (s_stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_i_byte     (o_i_byte),
        .o_q_byte     (o_q_byte),
        .o_over_range (o_over_range)
    );

endmodule

// ===== hdl/mcam_checker.sv =====
module mcam_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [7:0]                          o_i_byte,
    input logic [7:0]                          o_q_byte,
    input logic                                o_over_range
);

    // one word in flight: an accept closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // a new result appears only from the busy sequence
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result word without work");

    // over-range is sticky until reset
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_over_range |=> o_over_range)
        else $error("over-range flag dropped");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_i_byte) && $stable(o_q_byte)))
        else $error("stalled result word changed");

endmodule

bind multi_carrier_am_iq_generator mcam_checker u_mcam_checker (.*);
